>>> rtl/skqu_pkg.sv
// ----------------------------------------------------------------------------
// skqu_pkg
// Shared types and codes for the sorted key list queue and its cells.
// ----------------------------------------------------------------------------
package skqu_pkg;

   localparam int KEY_W    = 32;
   localparam int ITEM_W   = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_PREPEND       = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND        = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_FIRST  = 3'd2;
   localparam logic [OP_W-1:0] OP_SORTED_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_SORTED_REMOVE = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic                     valid;
      logic signed [KEY_W-1:0]  key;
      logic [ITEM_W-1:0]        item;
   } entry_type;

   typedef struct packed {
      logic              ge;
      logic              gt;
      logic              eq;
      logic [ITEM_W-1:0] hit_item;
   } flags_type;

   typedef struct packed {
      logic                    accept;
      logic [OP_W-1:0]         op;
      logic [ITEM_W-1:0]       item;
      logic signed [KEY_W-1:0] key;
      logic                    full;
      logic                    tail_ok;
      logic                    found;
   } ctrl_type;

endpackage

>>> rtl/skqu_cell.sv
// ----------------------------------------------------------------------------
// skqu_cell
// One list position: holds an entry, compares it with the broadcast key and
// takes its next entry from itself, a neighbor or the incoming transaction.
// ----------------------------------------------------------------------------
module skqu_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_cell,
   input  skqu_pkg::ctrl_type  ctrl,
   input  skqu_pkg::entry_type left_entry,
   input  skqu_pkg::flags_type left_flags,
   input  skqu_pkg::entry_type right_entry,
   output skqu_pkg::entry_type own_entry,
   output skqu_pkg::flags_type own_flags
);

   skqu_pkg::entry_type entry_ff;
   skqu_pkg::entry_type entry_in;
   logic signed [skqu_pkg::KEY_W-1:0] dec_key;
   logic signed [skqu_pkg::KEY_W-1:0] inc_key;
   logic ge;

   assign ge = entry_ff.valid && (entry_ff.key >= ctrl.key);

   assign own_entry          = entry_ff;
   assign own_flags.ge       = ge;
   assign own_flags.gt       = entry_ff.valid && (entry_ff.key > ctrl.key);
   assign own_flags.eq       = entry_ff.valid && (entry_ff.key == ctrl.key);
   assign own_flags.hit_item = (own_flags.eq && !left_flags.eq) ? entry_ff.item : '0;

   // saturating neighbor keys for prepend and append
   assign dec_key = (entry_ff.key == skqu_pkg::KEY_MIN) ? skqu_pkg::KEY_MIN
                                                         : entry_ff.key - 32'sd1;
   assign inc_key = (left_entry.key == skqu_pkg::KEY_MAX) ? skqu_pkg::KEY_MAX
                                                           : left_entry.key + 32'sd1;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.accept) begin
         unique case (ctrl.op)
            skqu_pkg::OP_PREPEND: begin
               if (!ctrl.full) begin
                  if (head_cell) begin
                     entry_in.valid = 1'b1;
                     entry_in.key   = entry_ff.valid ? dec_key : '0;
                     entry_in.item  = ctrl.item;
                  end else begin
                     entry_in = left_entry;
                  end
               end
            end
            skqu_pkg::OP_APPEND: begin
               if (!ctrl.full && !entry_ff.valid && (left_entry.valid || head_cell)) begin
                  entry_in.valid = 1'b1;
                  entry_in.key   = head_cell ? '0 : inc_key;
                  entry_in.item  = ctrl.item;
               end
            end
            skqu_pkg::OP_REMOVE_FIRST: begin
               if (entry_ff.valid) begin
                  entry_in = right_entry;
               end
            end
            skqu_pkg::OP_SORTED_INSERT: begin
               if (!ctrl.full) begin
                  if (ctrl.tail_ok) begin
                     if (!entry_ff.valid && (left_entry.valid || head_cell)) begin
                        entry_in.valid = 1'b1;
                        entry_in.key   = ctrl.key;
                        entry_in.item  = ctrl.item;
                     end
                  end else if (ge || (!entry_ff.valid && left_flags.ge)) begin
                     if (left_flags.ge) begin
                        entry_in = left_entry;
                     end else begin
                        entry_in.valid = 1'b1;
                        entry_in.key   = ctrl.key;
                        entry_in.item  = ctrl.item;
                     end
                  end
               end
            end
            skqu_pkg::OP_SORTED_REMOVE: begin
               if (ctrl.found && ge) begin
                  entry_in = right_entry;
               end
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.key  <= entry_in.key;
      entry_ff.item <= entry_in.item;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

endmodule

>>> rtl/sorted_key_list_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_list_queue_unit
// Bounded ascending list of key and item entries held in a row of cells.
// ----------------------------------------------------------------------------
// Each cell compares its key with the request key and moves by one place
// together with its neighbors, so a new request can be accepted in every
// cycle while the previous response is taken. The response appears in the
// cycle after its request is accepted and is held in an output register; the
// per-cycle work is set by one key compare per cell and an or-reduction of the
// match flags across CAPACITY cells.
module sorted_key_list_queue_unit #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[2:0], item_value[34:3], key_in[66:35], zero fill
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // item_out[31:0], key_out[63:32], status[65:64], list_empty[66],
   // entry_count[71:67]
   output logic [71:0] rsp_tdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   skqu_pkg::ctrl_type  ctrl;
   skqu_pkg::entry_type entry_vec [CAPACITY];
   skqu_pkg::flags_type flags_vec [CAPACITY];
   skqu_pkg::entry_type left_vec  [CAPACITY];
   skqu_pkg::flags_type left_fvec [CAPACITY];
   skqu_pkg::entry_type right_vec [CAPACITY];

   logic [CAPACITY-1:0] valid_vec;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W+4:0]    count_wide;
   logic                rsp_tvalid_ff;
   logic [71:0]         rsp_tdata_ff;
   logic [71:0]         rsp_tdata_in;
   logic                accept;
   logic                empty;
   logic                any_gt;
   logic                any_eq;
   logic [skqu_pkg::ITEM_W-1:0]   hit_item;
   logic [skqu_pkg::ITEM_W-1:0]   item_res;
   logic signed [skqu_pkg::KEY_W-1:0] key_res;
   logic [skqu_pkg::STATUS_W-1:0] status_res;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign empty      = (count_ff == '0);

   assign ctrl.accept  = accept;
   assign ctrl.op      = req_tdata[2:0];
   assign ctrl.item    = req_tdata[34:3];
   assign ctrl.key     = req_tdata[66:35];
   assign ctrl.full    = (count_ff >= CNT_W'(CAPACITY));
   // a key at most the head key goes to the front, even when all keys are equal
   assign ctrl.tail_ok = !any_gt && !flags_vec[0].ge;
   assign ctrl.found   = any_eq;

   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
         assign left_vec[gi]  = '0;
         assign left_fvec[gi] = '0;
      end else begin : g_inner
         assign left_vec[gi]  = entry_vec[gi-1];
         assign left_fvec[gi] = flags_vec[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
         assign right_vec[gi] = '0;
      end else begin : g_body
         assign right_vec[gi] = entry_vec[gi+1];
      end
      assign valid_vec[gi] = entry_vec[gi].valid;

      skqu_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .head_cell   (gi == 0),
         .ctrl        (ctrl),
         .left_entry  (left_vec[gi]),
         .left_flags  (left_fvec[gi]),
         .right_entry (right_vec[gi]),
         .own_entry   (entry_vec[gi]),
         .own_flags   (flags_vec[gi])
      );
   end

   always_comb begin
      any_gt   = 1'b0;
      any_eq   = 1'b0;
      hit_item = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_gt   = any_gt | flags_vec[i].gt;
         any_eq   = any_eq | flags_vec[i].eq;
         hit_item = hit_item | flags_vec[i].hit_item;
      end
   end

   always_comb begin
      item_res   = '0;
      key_res    = '0;
      status_res = skqu_pkg::STATUS_OK;
      count_in   = count_ff;
      unique case (ctrl.op)
         skqu_pkg::OP_PREPEND, skqu_pkg::OP_APPEND, skqu_pkg::OP_SORTED_INSERT: begin
            if (ctrl.full) begin
               status_res = skqu_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         skqu_pkg::OP_REMOVE_FIRST: begin
            if (empty) begin
               status_res = skqu_pkg::STATUS_EMPTY;
            end else begin
               item_res = entry_vec[0].item;
               key_res  = entry_vec[0].key;
               count_in = count_ff - CNT_W'(1);
            end
         end
         skqu_pkg::OP_SORTED_REMOVE: begin
            if (empty) begin
               status_res = skqu_pkg::STATUS_EMPTY;
            end else if (!any_eq) begin
               status_res = skqu_pkg::STATUS_NOT_FOUND;
            end else begin
               item_res = hit_item;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      count_wide   = {5'd0, count_in};
      rsp_tdata_in = {count_wide[4:0], (count_in == '0), status_res, key_res, item_res};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
      if (reset) begin
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // occupied cells always form a run from the head
   a_valid_run: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("occupied cells are not contiguous from the head");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("entry count disagrees with occupied cells");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid_ff)
      else $error("accepted transaction produced no response");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for sorted_key_list_queue_unit. It walks a table of
// directed list operations, then runs random operation mixes that sweep the
// list between empty and full, with random idling on both stream sides. Each
// response is checked against a fixed row result or the ordered list model.
// ----------------------------------------------------------------------------
module testbench;
   import skqu_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int DIR_ROWS    = 25;
   localparam int PHASE_OPS   = 480;
   localparam int HOLD_CYCLES = 300;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [ITEM_W-1:0]       item;
      logic [OP_W-1:0]         op;
   } queue_op_type;

   typedef struct packed {
      logic [COUNT_W-1:0]      count;
      logic                    empty;
      logic [STATUS_W-1:0]     status;
      logic signed [KEY_W-1:0] key;
      logic [ITEM_W-1:0]       item;
   } queue_rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [ITEM_W-1:0]       item;
      logic signed [KEY_W-1:0] key;
      logic [7:0]              reps;
      logic                    fixed;
      queue_rsp_type           rsp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;

   // local copy of the ordered list
   logic signed [KEY_W-1:0] held_keys  [QUEUE_DEPTH];
   logic [ITEM_W-1:0]       held_items [QUEUE_DEPTH];
   int                      held_count;

   queue_rsp_type pending_results [$];
   logic          row_fixed;
   queue_rsp_type row_rsp;
   int            failures;
   int            send_idle_pct;
   int            recv_stall_pct;
   bit            hold_request;
   bit            grow;

   dir_row_type dir_table [DIR_ROWS] = '{
      '{OP_REMOVE_FIRST,  32'h0000_0000, 32'sd0,   8'd1, 1'b1,
        '{5'd0, 1'b1, STATUS_EMPTY, 32'sd0, 32'h0}},
      '{OP_SORTED_REMOVE, 32'h0000_0000, 32'sd5,   8'd1, 1'b1,
        '{5'd0, 1'b1, STATUS_EMPTY, 32'sd0, 32'h0}},
      '{OP_PREPEND,       32'hffff_ffff, KEY_MAX,  8'd1, 1'b1,
        '{5'd1, 1'b0, STATUS_OK, 32'sd0, 32'h0}},
      '{OP_APPEND,        32'h0000_0000, KEY_MIN,  8'd1, 1'b1,
        '{5'd2, 1'b0, STATUS_OK, 32'sd0, 32'h0}},
      '{OP_REMOVE_FIRST,  32'h0000_0000, 32'sd0,   8'd1, 1'b1,
        '{5'd1, 1'b0, STATUS_OK, 32'sd0, 32'hffff_ffff}},
      '{OP_SORTED_INSERT, 32'ha5a5_a5a5, KEY_MIN,  8'd1, 1'b0, '0},
      '{OP_PREPEND,       32'h1234_5678, 32'sd0,   8'd1, 1'b0, '0},
      '{OP_REMOVE_FIRST,  32'h0000_0000, 32'sd0,   8'd1, 1'b1,
        '{5'd2, 1'b0, STATUS_OK, KEY_MIN, 32'h1234_5678}},
      '{OP_SORTED_INSERT, 32'h5a5a_5a5a, KEY_MAX,  8'd1, 1'b0, '0},
      '{OP_APPEND,        32'h0bad_f00d, 32'sd0,   8'd1, 1'b0, '0},
      '{OP_SORTED_REMOVE, 32'h0000_0000, KEY_MAX,  8'd1, 1'b1,
        '{5'd3, 1'b0, STATUS_OK, 32'sd0, 32'h5a5a_5a5a}},
      '{OP_SORTED_REMOVE, 32'h0000_0000, 32'sd7,   8'd1, 1'b1,
        '{5'd3, 1'b0, STATUS_NOT_FOUND, 32'sd0, 32'h0}},
      '{OP_SORTED_INSERT, 32'hc0ff_ee01, 32'sd1,   8'd1, 1'b0, '0},
      '{OP_SORTED_INSERT, 32'h600d_600d, 32'sd0,   8'd1, 1'b0, '0},
      '{OP_SORTED_INSERT, 32'h0000_0001, KEY_MIN,  8'd1, 1'b0, '0},
      '{OP_SORTED_INSERT, 32'hffff_0000, KEY_MAX,  8'd1, 1'b0, '0},
      '{OP_SPARE_A,       32'hffff_ffff, -32'sd1,  8'd1, 1'b1,
        '{5'd7, 1'b0, STATUS_OK, 32'sd0, 32'h0}},
      '{OP_SPARE_B,       32'hffff_ffff, -32'sd1,  8'd1, 1'b1,
        '{5'd7, 1'b0, STATUS_OK, 32'sd0, 32'h0}},
      '{OP_SPARE_C,       32'hffff_ffff, -32'sd1,  8'd1, 1'b1,
        '{5'd7, 1'b0, STATUS_OK, 32'sd0, 32'h0}},
      '{OP_APPEND,        32'h0000_0100, 32'sd0,   8'd9, 1'b0, '0},
      '{OP_PREPEND,       32'hdead_beef, 32'sd0,   8'd1, 1'b1,
        '{5'd16, 1'b0, STATUS_FULL, 32'sd0, 32'h0}},
      '{OP_APPEND,        32'hdead_beef, 32'sd0,   8'd1, 1'b1,
        '{5'd16, 1'b0, STATUS_FULL, 32'sd0, 32'h0}},
      '{OP_SORTED_INSERT, 32'hdead_beef, 32'sd3,   8'd1, 1'b1,
        '{5'd16, 1'b0, STATUS_FULL, 32'sd0, 32'h0}},
      '{OP_SORTED_REMOVE, 32'h0000_0000, KEY_MIN,  8'd1, 1'b0, '0},
      '{OP_REMOVE_FIRST,  32'h0000_0000, 32'sd0,   8'd1, 1'b0, '0}
   };

   sorted_key_list_queue_unit #(
      .CAPACITY(QUEUE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void shift_in(int pos, logic signed [KEY_W-1:0] key,
                                    logic [ITEM_W-1:0] item);
      for (int i = held_count; i > pos; i--) begin
         held_keys[i]  = held_keys[i-1];
         held_items[i] = held_items[i-1];
      end
      held_keys[pos]  = key;
      held_items[pos] = item;
      held_count++;
   endfunction

   function automatic void shift_out(int pos);
      for (int i = pos; i + 1 < held_count; i++) begin
         held_keys[i]  = held_keys[i+1];
         held_items[i] = held_items[i+1];
      end
      held_count--;
   endfunction

   function automatic queue_rsp_type list_op_result(queue_op_type cmd);
      queue_rsp_type           rsp;
      logic signed [KEY_W-1:0] want_key;
      logic signed [KEY_W-1:0] new_key;
      int                      pos;
      bit                      found;
      rsp      = '0;
      want_key = cmd.key;
      found    = 1'b0;
      case (cmd.op)
         OP_PREPEND, OP_APPEND, OP_SORTED_INSERT: begin
            if (held_count >= QUEUE_DEPTH) begin
               rsp.status = STATUS_FULL;
            end else if (cmd.op == OP_PREPEND) begin
               new_key = 32'sd0;
               if (held_count != 0)
                  new_key = (held_keys[0] == KEY_MIN) ? KEY_MIN : held_keys[0] - 1;
               shift_in(0, new_key, cmd.item);
            end else if (cmd.op == OP_APPEND) begin
               new_key = 32'sd0;
               if (held_count != 0)
                  new_key = (held_keys[held_count-1] == KEY_MAX) ?
                            KEY_MAX : held_keys[held_count-1] + 1;
               shift_in(held_count, new_key, cmd.item);
            end else begin
               if (held_count == 0 || want_key <= held_keys[0]) begin
                  pos = 0;
               end else if (want_key >= held_keys[held_count-1]) begin
                  pos = held_count;
               end else begin
                  pos = held_count;
                  for (int i = held_count - 1; i >= 1; i--)
                     if (held_keys[i] >= want_key) pos = i;
               end
               shift_in(pos, want_key, cmd.item);
            end
         end
         OP_REMOVE_FIRST: begin
            if (held_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               rsp.item = held_items[0];
               rsp.key  = held_keys[0];
               shift_out(0);
            end
         end
         OP_SORTED_REMOVE: begin
            if (held_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               rsp.status = STATUS_NOT_FOUND;
               for (int i = 0; i < held_count && !found; i++) begin
                  if (held_keys[i] == want_key) begin
                     rsp.item   = held_items[i];
                     rsp.status = STATUS_OK;
                     found      = 1'b1;
                     shift_out(i);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rsp.empty = (held_count == 0);
      rsp.count = held_count[COUNT_W-1:0];
      return rsp;
   endfunction

   function automatic logic signed [KEY_W-1:0] random_key();
      logic signed [KEY_W-1:0] k;
      int                      pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         k = $urandom_range(16);
         k = k - 8;
      end else if (pick < 50) begin
         case ($urandom_range(3))
            0:       k = KEY_MIN;
            1:       k = KEY_MAX;
            2:       k = KEY_MIN + 1;
            default: k = KEY_MAX - 1;
         endcase
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   // swings the list between empty and full so both ends get exercised
   function automatic queue_op_type random_op();
      queue_op_type cmd;
      int           pick;
      if (held_count >= QUEUE_DEPTH) grow = 1'b0;
      if (held_count == 0) grow = 1'b1;
      if ($urandom_range(49) == 0) grow = !grow;
      cmd.item = $urandom;
      cmd.key  = random_key();
      pick     = $urandom_range(99);
      if (pick < 3) begin
         case ($urandom_range(2))
            0:       cmd.op = OP_SPARE_A;
            1:       cmd.op = OP_SPARE_B;
            default: cmd.op = OP_SPARE_C;
         endcase
      end else if (pick < (grow ? 72 : 32)) begin
         case ($urandom_range(3))
            0:       cmd.op = OP_PREPEND;
            1:       cmd.op = OP_APPEND;
            default: cmd.op = OP_SORTED_INSERT;
         endcase
      end else if ($urandom_range(9) < 4) begin
         cmd.op = OP_REMOVE_FIRST;
      end else begin
         cmd.op = OP_SORTED_REMOVE;
         if (held_count != 0 && $urandom_range(9) < 7)
            cmd.key = held_keys[$urandom_range(held_count - 1)];
      end
      return cmd;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch %s: expected %h, actual %h", $time, field, want, got);
      failures++;
   endtask

   task automatic send_op(queue_op_type cmd, logic fixed, queue_rsp_type fixed_rsp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, cmd};
      row_fixed  <= fixed;
      row_rsp    <= fixed_rsp;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin : scoreboard
      queue_rsp_type got;
      queue_rsp_type want;
      queue_rsp_type predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = queue_rsp_type'(rsp_tdata);
            if (pending_results.size() == 0) begin
               $display("%0t unexpected transaction: expected none, actual %h",
                        $time, rsp_tdata);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (got.item !== want.item) report_mismatch("item_out", want.item, got.item);
               if (got.key !== want.key) report_mismatch("key_out", want.key, got.key);
               if (got.status !== want.status)
                  report_mismatch("status", want.status, got.status);
               if (got.empty !== want.empty)
                  report_mismatch("list_empty", want.empty, got.empty);
               if (got.count !== want.count)
                  report_mismatch("entry_count", want.count, got.count);
            end
         end
         if (req_tvalid && req_tready) begin
            predicted = list_op_result(queue_op_type'(req_tdata[66:0]));
            pending_results.push_back(row_fixed ? row_rsp : predicted);
         end
      end
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin : stimulus
      dir_row_type  row;
      queue_op_type cmd;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      row_fixed      = 1'b0;
      row_rsp        = '0;
      failures       = 0;
      held_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      grow           = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int t = 0; t < DIR_ROWS; t++) begin
         row = dir_table[t];
         for (int rep = 0; rep < row.reps; rep++) begin
            cmd.op   = row.op;
            cmd.item = row.item + rep;
            cmd.key  = row.key;
            send_op(cmd, row.fixed, row.rsp);
         end
      end

      // no idling, sender idle, receiver stalling, then both
      for (int ph = 0; ph < 4; ph++) begin
         drain_results();
         send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 12 : 0;
         recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 12 : 0;
         for (int n = 0; n < PHASE_OPS; n++) begin
            if (ph == 0 && n == 100) hold_request = 1'b1;
            send_op(random_op(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
